// File: hdl/rgb_pixel_blend_unit_core_assert.svh
// ----------------------------------------------------------------------------
// rgb pixel blend unit assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef RGB_PIXEL_BLEND_UNIT_CORE_ASSERT_SVH
`define RGB_PIXEL_BLEND_UNIT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked on clk_i, disabled while rst_ni is low
`define RPB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rpb assertion failed");
// explicit clock and active-low reset
`define RPB_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rpb assertion failed");
`else
`define RPB_ASSERT(lbl, prop)
`define RPB_ASSERT_CLK(lbl, clk, rst_n, prop)
`endif

`endif

// File: hdl/rpb_pkg.sv
// ----------------------------------------------------------------------------
// rpb_pkg
// shared types and constants of the rgb pixel blend unit
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned PixW     = NumChan * ChanW;
  localparam int unsigned InDataW  = 2 * PixW;
  localparam int unsigned OutDataW = PixW;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned GainW    = 9;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [ModeW-1:0] {
    ModeMultiply = 3'd0,
    ModeScreen   = 3'd1,
    ModeOverlay  = 3'd2,
    ModeAdd      = 3'd3,
    ModeSubtract = 3'd4,
    ModeScale    = 3'd5
  } blend_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegBlendMode = 8'd0,
    RegGainBlue  = 8'd1,
    RegGainGreen = 8'd2,
    RegGainRed   = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [GainW-1:0] gain_blue;
    logic signed [GainW-1:0] gain_green;
    logic signed [GainW-1:0] gain_red;
  } cfg_t;

  localparam logic signed [GainW-1:0] GainReset = 9'sd1;

endpackage

// File: hdl/rpb_cfg.sv
// ----------------------------------------------------------------------------
// rpb_cfg
// configuration registers: blend mode and per-channel scale gains
// ----------------------------------------------------------------------------
module rpb_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [rpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpb_pkg::CfgDataW-1:0] cfg_data_i,
  output rpb_pkg::cfg_t                cfg_o
);
  import rpb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBlendMode: cfg_d.mode       = cfg_data_i[ModeW-1:0];
        RegGainBlue:  cfg_d.gain_blue  = cfg_data_i[GainW-1:0];
        RegGainGreen: cfg_d.gain_green = cfg_data_i[GainW-1:0];
        RegGainRed:   cfg_d.gain_red   = cfg_data_i[GainW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= ModeMultiply;
      cfg_q.gain_blue  <= GainReset;
      cfg_q.gain_green <= GainReset;
      cfg_q.gain_red   <= GainReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/rpb_channel.sv
// ----------------------------------------------------------------------------
// rpb_channel
// blend of one color channel; one shared signed multiplier serves the multiply, screen, overlay and scale modes
// ----------------------------------------------------------------------------
module rpb_channel (
  input  logic [rpb_pkg::ModeW-1:0]        mode_i,
  input  logic [rpb_pkg::ChanW-1:0]        top_i,
  input  logic [rpb_pkg::ChanW-1:0]        bottom_i,
  input  logic signed [rpb_pkg::GainW-1:0] gain_i,
  output logic [rpb_pkg::ChanW-1:0]        result_o
);
  import rpb_pkg::*;

  logic                inv;
  logic                dbl;
  logic [ChanW-1:0]    op_a;
  logic [ChanW-1:0]    op_b;
  logic signed [8:0]   mul_a;
  logic signed [8:0]   mul_b;
  logic signed [17:0]  prod;
  logic [16:0]         num;
  logic [17:0]         est_sum;
  logic [9:0]          q_est;
  logic [17:0]         q_est_x255;
  logic [17:0]         rem;
  logic [ChanW-1:0]    quot;
  logic [ChanW-1:0]    blend_res;
  logic [ChanW-1:0]    scale_res;
  logic [ChanW:0]      add_sum;
  logic [ChanW-1:0]    add_res;
  logic [ChanW-1:0]    sub_res;

  // 255 - x is the bitwise complement for 8-bit values
  assign inv  = (mode_i == ModeScreen) || ((mode_i == ModeOverlay) && bottom_i[ChanW-1]);
  assign dbl  = (mode_i == ModeOverlay);
  assign op_a = inv ? ~top_i : top_i;
  assign op_b = inv ? ~bottom_i : bottom_i;

  assign mul_a = $signed({1'b0, op_a});
  assign mul_b = (mode_i == ModeScale) ? gain_i : $signed({1'b0, op_b});
  assign prod  = mul_a * mul_b;

  // rounded divide by 255: estimate x*257/65536, then one correction step
  assign num        = (dbl ? {prod[15:0], 1'b0} : {1'b0, prod[15:0]}) + 17'd127;
  assign est_sum    = {1'b0, num} + {9'd0, num[16:8]};
  assign q_est      = est_sum[17:8];
  assign q_est_x255 = {q_est, 8'd0} - {8'd0, q_est};
  assign rem        = {1'b0, num} - q_est_x255;
  assign quot       = q_est[ChanW-1:0] + ChanW'(rem >= 18'd255);
  assign blend_res  = inv ? ~quot : quot;

  assign scale_res = prod[17]           ? '0 :
                     (prod[16:8] != '0) ? '1 : prod[7:0];

  assign add_sum = {1'b0, top_i} + {1'b0, bottom_i};
  assign add_res = add_sum[ChanW] ? '1 : add_sum[ChanW-1:0];
  assign sub_res = (top_i > bottom_i) ? (top_i - bottom_i) : '0;

  always_comb begin
    case (mode_i) inside
      ModeMultiply, ModeScreen, ModeOverlay: result_o = blend_res;
      ModeAdd:      result_o = add_res;
      ModeSubtract: result_o = sub_res;
      ModeScale:    result_o = scale_res;
      default:      result_o = top_i;
    endcase
  end

endmodule

// File: hdl/rgb_pixel_blend_unit_core.sv
// ----------------------------------------------------------------------------
// rgb_pixel_blend_unit_core
// blends a top and a bottom bgr pixel per item: multiply, screen, overlay,
// add, subtract or per-channel scale
// ----------------------------------------------------------------------------
// channel   direction  fields (lsb first)
// s_axis    in         top_blue, top_green, top_red,
//                      bottom_blue, bottom_green, bottom_red (8 bits each)
// m_axis    out        out_blue, out_green, out_red (8 bits each)
// cfg       in         index 0 blend_mode, 1..3 gain_blue/green/red
//
// one pixel pair per cycle while the result register is not stalled; input register
// to result register, with the three channel datapaths and their multipliers between
// reset clears the valid flags and sets mode multiply, gains one
// a stalled result register holds; the input register still takes an item
// while it is empty, and holds it until the result register frees
// cfg is always ready
// ----------------------------------------------------------------------------
`include "rgb_pixel_blend_unit_core_assert.svh"

module rgb_pixel_blend_unit_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red
  input  logic [rpb_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // out_blue, out_green, out_red
  output logic [rpb_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpb_pkg::CfgDataW-1:0] cfg_data_i
);
  import rpb_pkg::*;

  cfg_t                    cfg;
  logic                    in_valid_q, in_valid_d;
  logic [InDataW-1:0]      in_data_q;
  logic                    out_valid_q, out_valid_d;
  logic [OutDataW-1:0]     out_data_q, out_data_d;
  logic                    out_en;
  logic                    in_en;
  logic signed [GainW-1:0] gain_sel [NumChan];

  assign cfg_ready_o = 1'b1;

  rpb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign gain_sel[0] = cfg.gain_blue;
  assign gain_sel[1] = cfg.gain_green;
  assign gain_sel[2] = cfg.gain_red;

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_chan
    rpb_channel u_channel (
      .mode_i   (cfg.mode),
      .top_i    (in_data_q[ch*ChanW +: ChanW]),
      .bottom_i (in_data_q[PixW + ch*ChanW +: ChanW]),
      .gain_i   (gain_sel[ch]),
      .result_o (out_data_d[ch*ChanW +: ChanW])
    );
  end

  assign out_en          = !out_valid_q || m_axis_tready_i;
  assign in_en           = !in_valid_q || out_en;
  assign s_axis_tready_o = in_en;

  assign in_valid_d  = in_en ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = out_en ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (out_en && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  `RPB_ASSERT(a_accept_fills_input, (s_axis_tvalid_i && s_axis_tready_o) |=> in_valid_q)
  `RPB_ASSERT(a_blocked_input_holds, (in_valid_q && !out_en) |=> (in_valid_q && $stable(in_data_q)))
  `RPB_ASSERT(a_advance_fills_result, (in_valid_q && out_en) |=> m_axis_tvalid_o)
  `RPB_ASSERT(a_mode_write, (cfg_valid_i && (cfg_index_i == RegBlendMode)) |=> (cfg.mode == $past(cfg_data_i[ModeW-1:0])))

endmodule
